### hdl/msq_pkg.sv
`timescale 1ns / 1ps
package msq_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int VALUE_BITS_DEF = 16;

	// classification codes with a meaning of their own
	localparam logic [3:0] CASE_EMPTY    = 4'd0;
	localparam logic [3:0] CASE_FULL     = 4'd15;
	localparam logic [3:0] CASE_SADDLE_5 = 4'd5;
	localparam logic [3:0] CASE_SADDLE_A = 4'd10;

	// corner weights
	localparam logic [3:0] W_TL = 4'b1000;
	localparam logic [3:0] W_TR = 4'b0100;
	localparam logic [3:0] W_BR = 4'b0010;
	localparam logic [3:0] W_BL = 4'b0001;

	typedef enum logic [1:0] {
		EDGE_TOP    = 2'd0,
		EDGE_RIGHT  = 2'd1,
		EDGE_BOTTOM = 2'd2,
		EDGE_LEFT   = 2'd3
	} edge_t;

	typedef struct packed {
		edge_t from_edge;
		edge_t to_edge;
	} seg_edges_t;

	function automatic logic is_saddle(input logic [3:0] cs);
		is_saddle = (cs == CASE_SADDLE_5) || (cs == CASE_SADDLE_A);
	endfunction

	function automatic logic is_empty(input logic [3:0] cs);
		is_empty = (cs == CASE_EMPTY) || (cs == CASE_FULL);
	endfunction

	// segment edges for a case; second picks the later saddle segment
	function automatic seg_edges_t seg_edges(input logic [3:0] cs, input logic low,
		input logic second);
		seg_edges_t s;
		s = '{EDGE_TOP, EDGE_TOP};
		case (cs)
			4'd1:  s = '{EDGE_LEFT, EDGE_BOTTOM};
			4'd2:  s = '{EDGE_BOTTOM, EDGE_RIGHT};
			4'd3:  s = '{EDGE_LEFT, EDGE_RIGHT};
			4'd4:  s = '{EDGE_RIGHT, EDGE_TOP};
			CASE_SADDLE_5: begin
				if (!second)
					s = low ? seg_edges_t'{EDGE_RIGHT, EDGE_TOP} :
						seg_edges_t'{EDGE_LEFT, EDGE_TOP};
				else
					s = low ? seg_edges_t'{EDGE_LEFT, EDGE_BOTTOM} :
						seg_edges_t'{EDGE_RIGHT, EDGE_BOTTOM};
			end
			4'd6:  s = '{EDGE_BOTTOM, EDGE_TOP};
			4'd7:  s = '{EDGE_LEFT, EDGE_TOP};
			4'd8:  s = '{EDGE_TOP, EDGE_LEFT};
			4'd9:  s = '{EDGE_TOP, EDGE_BOTTOM};
			CASE_SADDLE_A: begin
				if (!second)
					s = low ? seg_edges_t'{EDGE_TOP, EDGE_LEFT} :
						seg_edges_t'{EDGE_TOP, EDGE_RIGHT};
				else
					s = low ? seg_edges_t'{EDGE_BOTTOM, EDGE_RIGHT} :
						seg_edges_t'{EDGE_BOTTOM, EDGE_LEFT};
			end
			4'd11: s = '{EDGE_TOP, EDGE_RIGHT};
			4'd12: s = '{EDGE_RIGHT, EDGE_LEFT};
			4'd13: s = '{EDGE_RIGHT, EDGE_BOTTOM};
			4'd14: s = '{EDGE_BOTTOM, EDGE_LEFT};
			default: s = '{EDGE_TOP, EDGE_TOP};
		endcase
		seg_edges = s;
	endfunction

endpackage

### hdl/marching_squares_cell_top.sv
`timescale 1ns / 1ps
// channel   | direction | transaction moment            | payload
// command   | in        | start && !busy at clk rise    | corners, cell_x, cell_y, threshold
// segment   | out       | strobe high for one cycle     | start/end x,y, case_index, last_segment
//
// path from command to first segment: one classify stage,
// a FRAC_BITS+1 stage radix-2 divider per edge, the queue write and the output register
// a new command may be taken every cycle while busy is low; the segment port gives
// one segment a cycle, so a saddle cell holds it for two segments, a single-segment cell for one
// busy rises when FRAC_BITS+8 commands are taken but not yet drained from the queue
// reset (arst_n low) empties pipeline and queue; no clearing pass is needed
// the receiver cannot stall: each strobe is a completed transaction
module marching_squares_cell_top import msq_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [VALUE_BITS-1:0]           corner_top_left,
	input  logic [VALUE_BITS-1:0]           corner_top_right,
	input  logic [VALUE_BITS-1:0]           corner_bottom_left,
	input  logic [VALUE_BITS-1:0]           corner_bottom_right,
	input  logic [COORD_BITS-1:0]           cell_x,
	input  logic [COORD_BITS-1:0]           cell_y,
	input  logic [VALUE_BITS-1:0]           threshold,
	output logic                            strobe,
	output logic [COORD_BITS+FRAC_BITS-1:0] start_x,
	output logic [COORD_BITS+FRAC_BITS-1:0] start_y,
	output logic [COORD_BITS+FRAC_BITS-1:0] end_x,
	output logic [COORD_BITS+FRAC_BITS-1:0] end_y,
	output logic [3:0]                      case_index,
	output logic                            last_segment
);

	localparam int META_W = 2 * COORD_BITS + 5;
	localparam int QW     = FRAC_BITS + 1;
	localparam int ENT_W  = META_W + 4 * QW;
	// enough credits to cover the divider pipeline with room to spare
	localparam int DEPTH  = FRAC_BITS + 8;
	localparam int CW     = $clog2(DEPTH + 1);

	logic                    take;
	logic                    vld_s1;
	logic [4*VALUE_BITS-1:0] num_s1, den_s1;
	logic [META_W-1:0]       meta_s1;
	logic                    div_vld;
	logic [4*QW-1:0]         div_quo;
	logic [META_W-1:0]       div_meta;
	logic                    head_vld, pop;
	logic [ENT_W-1:0]        head;
	logic [CW-1:0]           credit_q;

	// commands in flight or queued; bounded by the queue depth
	assign take = start && !busy;
	assign busy = credit_q == CW'(DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + CW'(take) - CW'(pop);
		end
	end

	// classify and form edge operands
	msq_front #(.COORD_BITS(COORD_BITS), .VALUE_BITS(VALUE_BITS)) u_front (
		.clk, .arst_n, .take,
		.corner_top_left, .corner_top_right, .corner_bottom_left, .corner_bottom_right,
		.cell_x, .cell_y, .threshold,
		.vld_s1, .num_s1, .den_s1, .meta_s1
	);

	// crossing fractions on the top, right, bottom and left edges
	msq_div #(.FRAC_BITS(FRAC_BITS), .VALUE_BITS(VALUE_BITS), .META_W(META_W)) u_div (
		.clk, .arst_n,
		.in_vld(vld_s1), .in_num(num_s1), .in_den(den_s1), .in_meta(meta_s1),
		.out_vld(div_vld), .out_quo(div_quo), .out_meta(div_meta)
	);

	// decouples the divider from the segment emitter
	msq_fifo #(.W(ENT_W), .DEPTH(DEPTH)) u_fifo (
		.clk, .arst_n,
		.push(div_vld), .wdata({div_meta, div_quo}),
		.pop, .not_empty(head_vld), .rdata(head)
	);

	// one or two segments per cell, none for empty or full cells
	msq_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n,
		.head_vld, .head_meta(head[ENT_W-1 -: META_W]), .head_quo(head[4*QW-1:0]),
		.pop, .strobe, .start_x, .start_y, .end_x, .end_y, .case_index, .last_segment
	);

	// the first segment of a saddle is always followed by its partner
	a_saddle_pair: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_segment |=> strobe && last_segment)
		else $error("saddle second segment missing");

	// only saddle cells produce a non-final segment
	a_non_last_saddle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_segment |-> case_index == CASE_SADDLE_5 ||
			case_index == CASE_SADDLE_A)
		else $error("non-final segment outside a saddle");

	// empty and full cells never show on the output
	a_no_empty: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> case_index != CASE_EMPTY && case_index != CASE_FULL)
		else $error("segment from empty or full cell");

	// credit never passes the queue depth
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= CW'(DEPTH))
		else $error("credit overflow");

endmodule

### hdl/msq_front.sv
`timescale 1ns / 1ps
module msq_front import msq_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      take,
	input  logic [VALUE_BITS-1:0]     corner_top_left,
	input  logic [VALUE_BITS-1:0]     corner_top_right,
	input  logic [VALUE_BITS-1:0]     corner_bottom_left,
	input  logic [VALUE_BITS-1:0]     corner_bottom_right,
	input  logic [COORD_BITS-1:0]     cell_x,
	input  logic [COORD_BITS-1:0]     cell_y,
	input  logic [VALUE_BITS-1:0]     threshold,
	output logic                      vld_s1,
	output logic [4*VALUE_BITS-1:0]   num_s1,
	output logic [4*VALUE_BITS-1:0]   den_s1,
	output logic [2*COORD_BITS+4:0]   meta_s1
);

	logic [3:0]            cs;
	logic [VALUE_BITS+1:0] sum;
	logic                  low;
	logic [VALUE_BITS-1:0] n_top, n_right, n_bottom, n_left;
	logic [VALUE_BITS-1:0] d_top, d_right, d_bottom, d_left;

	function automatic logic [VALUE_BITS-1:0] absdiff(input logic [VALUE_BITS-1:0] p,
		input logic [VALUE_BITS-1:0] q);
		absdiff = (p >= q) ? p - q : q - p;
	endfunction

	always_comb begin
		cs = ((corner_top_left > threshold) ? W_TL : 4'b0) |
		     ((corner_top_right > threshold) ? W_TR : 4'b0) |
		     ((corner_bottom_right > threshold) ? W_BR : 4'b0) |
		     ((corner_bottom_left > threshold) ? W_BL : 4'b0);
		sum = {2'b0, corner_top_left} + {2'b0, corner_top_right} +
		      {2'b0, corner_bottom_left} + {2'b0, corner_bottom_right};
		low = sum < {threshold, 2'b00};
		// fraction runs from the first named corner of each edge
		n_top    = absdiff(threshold, corner_top_left);
		d_top    = absdiff(corner_top_right, corner_top_left);
		n_right  = absdiff(threshold, corner_top_right);
		d_right  = absdiff(corner_bottom_right, corner_top_right);
		n_bottom = absdiff(threshold, corner_bottom_left);
		d_bottom = absdiff(corner_bottom_right, corner_bottom_left);
		n_left   = absdiff(threshold, corner_top_left);
		d_left   = absdiff(corner_bottom_left, corner_top_left);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			num_s1  <= {n_left, n_bottom, n_right, n_top};
			den_s1  <= {d_left, d_bottom, d_right, d_top};
			meta_s1 <= {cell_x, cell_y, cs, low};
		end
	end

endmodule

### hdl/msq_div.sv
`timescale 1ns / 1ps
module msq_div import msq_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int META_W     = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_vld,
	input  logic [4*VALUE_BITS-1:0]    in_num,
	input  logic [4*VALUE_BITS-1:0]    in_den,
	input  logic [META_W-1:0]          in_meta,
	output logic                       out_vld,
	output logic [4*(FRAC_BITS+1)-1:0] out_quo,
	output logic [META_W-1:0]          out_meta
);

	localparam int NST = FRAC_BITS + 1;
	localparam int RW  = VALUE_BITS + 1;
	localparam int QW  = FRAC_BITS + 1;

	// a stage for each quotient bit, msb first, and a lane for each edge side by side
	logic              vld_sn  [NST];
	logic [META_W-1:0] meta_sn [NST];
	logic [RW-1:0]     rem_sn  [NST][4];
	logic [VALUE_BITS-1:0] den_sn [NST][4];
	logic [QW-1:0]     quo_sn  [NST][4];

	genvar k, l;
	generate
		for (k = 0; k < NST; k++) begin : g_st
			logic prv_vld;
			logic [META_W-1:0] prv_meta;
			always_comb begin
				if (k == 0) begin
					prv_vld  = in_vld;
					prv_meta = in_meta;
				end else begin
					prv_vld  = vld_sn[(k == 0) ? 0 : k-1];
					prv_meta = meta_sn[(k == 0) ? 0 : k-1];
				end
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_sn[k] <= 1'b0;
				end else begin
					vld_sn[k] <= prv_vld;
				end
			end
			always_ff @(posedge clk) begin
				meta_sn[k] <= prv_meta;
			end
			for (l = 0; l < 4; l++) begin : g_ln
				logic [RW-1:0]         r_in;
				logic [VALUE_BITS-1:0] d_in;
				logic [QW-1:0]         q_in;
				logic                  qb;
				always_comb begin
					if (k == 0) begin
						r_in = {1'b0, in_num[l*VALUE_BITS +: VALUE_BITS]};
						d_in = in_den[l*VALUE_BITS +: VALUE_BITS];
						q_in = '0;
					end else begin
						r_in = {rem_sn[(k == 0) ? 0 : k-1][l][RW-2:0], 1'b0};
						d_in = den_sn[(k == 0) ? 0 : k-1][l];
						q_in = quo_sn[(k == 0) ? 0 : k-1][l];
					end
					qb = r_in >= {1'b0, d_in};
				end
				always_ff @(posedge clk) begin
					rem_sn[k][l] <= qb ? r_in - {1'b0, d_in} : r_in;
					den_sn[k][l] <= d_in;
					quo_sn[k][l] <= {q_in[QW-2:0], qb};
				end
			end
		end
		for (l = 0; l < 4; l++) begin : g_out
			assign out_quo[l*QW +: QW] = quo_sn[NST-1][l];
		end
	endgenerate

	assign out_vld  = vld_sn[NST-1];
	assign out_meta = meta_sn[NST-1];

endmodule

### hdl/msq_fifo.sv
`timescale 1ns / 1ps
module msq_fifo import msq_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic         not_empty,
	output logic [W-1:0] rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  head_q;
	logic          head_vld_q;
	logic          load, from_mem, bypass, wr_en;

	// head register refills from the array, or straight from the input when the array is empty
	always_comb begin
		load     = !head_vld_q || pop;
		from_mem = load && (cnt_q != '0);
		bypass   = load && (cnt_q == '0) && push;
		wr_en    = push && !bypass;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q       <= '0;
			rd_q       <= '0;
			cnt_q      <= '0;
			head_vld_q <= 1'b0;
		end else begin
			if (wr_en)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (from_mem)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + CW'(wr_en) - CW'(from_mem);
			if (load)
				head_vld_q <= from_mem || bypass;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_q] <= wdata;
		if (from_mem)
			head_q <= mem[rd_q];
		else if (bypass)
			head_q <= wdata;
	end

	assign rdata     = head_q;
	assign not_empty = head_vld_q;

endmodule

### hdl/msq_back.sv
`timescale 1ns / 1ps
module msq_back import msq_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            head_vld,
	input  logic [2*COORD_BITS+4:0]         head_meta,
	input  logic [4*(FRAC_BITS+1)-1:0]      head_quo,
	output logic                            pop,
	output logic                            strobe,
	output logic [COORD_BITS+FRAC_BITS-1:0] start_x,
	output logic [COORD_BITS+FRAC_BITS-1:0] start_y,
	output logic [COORD_BITS+FRAC_BITS-1:0] end_x,
	output logic [COORD_BITS+FRAC_BITS-1:0] end_y,
	output logic [3:0]                      case_index,
	output logic                            last_segment
);

	localparam int P  = COORD_BITS + FRAC_BITS;
	localparam int QW = FRAC_BITS + 1;
	localparam logic [P-1:0] ONE = P'(1) << FRAC_BITS;

	logic [COORD_BITS-1:0] cx, cy;
	logic [3:0]            cs;
	logic                  low, saddle, empty, emit;
	logic                  second_q;
	seg_edges_t            se;
	logic [P-1:0]          sx, sy, ex, ey;

	function automatic logic [2*P-1:0] point(input edge_t e,
		input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
		input logic [4*QW-1:0] q);
		logic [P-1:0] bx, by, px, py;
		bx = {x, {FRAC_BITS{1'b0}}};
		by = {y, {FRAC_BITS{1'b0}}};
		case (e)
			EDGE_TOP: begin
				px = bx + P'(q[0*QW +: QW]);
				py = by;
			end
			EDGE_RIGHT: begin
				px = bx + ONE;
				py = by + P'(q[1*QW +: QW]);
			end
			EDGE_BOTTOM: begin
				px = bx + P'(q[2*QW +: QW]);
				py = by + ONE;
			end
			default: begin
				px = bx;
				py = by + P'(q[3*QW +: QW]);
			end
		endcase
		point = {px, py};
	endfunction

	always_comb begin
		{cx, cy, cs, low} = head_meta;
		saddle = is_saddle(cs);
		empty  = is_empty(cs);
		emit   = head_vld && !empty;
		pop    = head_vld && (empty || !saddle || second_q);
		se     = seg_edges(cs, low, second_q);
		{sx, sy} = point(se.from_edge, cx, cy, head_quo);
		{ex, ey} = point(se.to_edge, cx, cy, head_quo);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q <= 1'b0;
			strobe   <= 1'b0;
		end else begin
			strobe <= emit;
			if (emit && saddle)
				second_q <= !second_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			start_x      <= sx;
			start_y      <= sy;
			end_x        <= ex;
			end_y        <= ey;
			case_index   <= cs;
			last_segment <= !saddle || second_q;
		end
	end

endmodule

### test/marching_squares_cell_top_tb.sv
`timescale 1ns / 1ps
module marching_squares_cell_top_tb import msq_pkg::*;;

	localparam int CB = COORD_BITS_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam int VB = VALUE_BITS_DEF;
	localparam int PW = CB + FB;

	typedef struct {
		logic [PW-1:0] sx, sy, ex, ey;
		logic [3:0]    cs;
		logic          last;
	} segment_t;

	// expected segments kept in arrival order; one cell gives zero to two
	class segment_board;
		segment_t pending[$];
		int       errors;
		int       checked;
		int       cells;
		int       saddles;

		function automatic logic [FB:0] crossing(logic [VB-1:0] a, logic [VB-1:0] b,
			logic [VB-1:0] iso);
			logic [VB+FB-1:0] num;
			logic [VB-1:0]    den;
			num = (VB+FB)'((iso >= a) ? iso - a : a - iso);
			den = (b >= a) ? b - a : a - b;
			if (den == 0)
				return '0;
			return (FB+1)'((num << FB) / den);
		endfunction

		// c: top-left, top-right, bottom-left, bottom-right
		function automatic void point(edge_t e, logic [VB-1:0] c[4], logic [CB-1:0] x,
			logic [CB-1:0] y, logic [VB-1:0] iso, output logic [PW-1:0] px,
			output logic [PW-1:0] py);
			logic [PW-1:0] bx, by;
			bx = {x, {FB{1'b0}}};
			by = {y, {FB{1'b0}}};
			case (e)
				EDGE_TOP: begin
					px = bx + PW'(crossing(c[0], c[1], iso));
					py = by;
				end
				EDGE_RIGHT: begin
					px = bx + PW'(1 << FB);
					py = by + PW'(crossing(c[1], c[3], iso));
				end
				EDGE_BOTTOM: begin
					px = bx + PW'(crossing(c[2], c[3], iso));
					py = by + PW'(1 << FB);
				end
				default: begin
					px = bx;
					py = by + PW'(crossing(c[0], c[2], iso));
				end
			endcase
		endfunction

		function automatic void add(edge_t e0, edge_t e1, logic [VB-1:0] c[4],
			logic [CB-1:0] x, logic [CB-1:0] y, logic [VB-1:0] iso, logic [3:0] cs,
			logic last);
			segment_t s;
			point(e0, c, x, y, iso, s.sx, s.sy);
			point(e1, c, x, y, iso, s.ex, s.ey);
			s.cs = cs;
			s.last = last;
			pending = {pending, s};
		endfunction

		function automatic void note_cell(logic [VB-1:0] c[4], logic [CB-1:0] x,
			logic [CB-1:0] y, logic [VB-1:0] iso);
			logic [3:0]  cs;
			logic [VB+2:0] total;
			logic        low;
			cells++;
			cs = (c[0] > iso ? W_TL : 4'b0) | (c[1] > iso ? W_TR : 4'b0) |
				(c[3] > iso ? W_BR : 4'b0) | (c[2] > iso ? W_BL : 4'b0);
			total = c[0] + c[1] + c[2] + c[3];
			low = total < ({3'b0, iso} << 2);
			case (cs)
				CASE_EMPTY, CASE_FULL: ;
				CASE_SADDLE_5: begin
					saddles++;
					if (low) begin
						add(EDGE_RIGHT, EDGE_TOP, c, x, y, iso, cs, 1'b0);
						add(EDGE_LEFT, EDGE_BOTTOM, c, x, y, iso, cs, 1'b1);
					end else begin
						add(EDGE_LEFT, EDGE_TOP, c, x, y, iso, cs, 1'b0);
						add(EDGE_RIGHT, EDGE_BOTTOM, c, x, y, iso, cs, 1'b1);
					end
				end
				CASE_SADDLE_A: begin
					saddles++;
					if (low) begin
						add(EDGE_TOP, EDGE_LEFT, c, x, y, iso, cs, 1'b0);
						add(EDGE_BOTTOM, EDGE_RIGHT, c, x, y, iso, cs, 1'b1);
					end else begin
						add(EDGE_TOP, EDGE_RIGHT, c, x, y, iso, cs, 1'b0);
						add(EDGE_BOTTOM, EDGE_LEFT, c, x, y, iso, cs, 1'b1);
					end
				end
				4'd1: add(EDGE_LEFT, EDGE_BOTTOM, c, x, y, iso, cs, 1'b1);
				4'd2: add(EDGE_BOTTOM, EDGE_RIGHT, c, x, y, iso, cs, 1'b1);
				4'd3: add(EDGE_LEFT, EDGE_RIGHT, c, x, y, iso, cs, 1'b1);
				4'd4: add(EDGE_RIGHT, EDGE_TOP, c, x, y, iso, cs, 1'b1);
				4'd6: add(EDGE_BOTTOM, EDGE_TOP, c, x, y, iso, cs, 1'b1);
				4'd7: add(EDGE_LEFT, EDGE_TOP, c, x, y, iso, cs, 1'b1);
				4'd8: add(EDGE_TOP, EDGE_LEFT, c, x, y, iso, cs, 1'b1);
				4'd9: add(EDGE_TOP, EDGE_BOTTOM, c, x, y, iso, cs, 1'b1);
				4'd11: add(EDGE_TOP, EDGE_RIGHT, c, x, y, iso, cs, 1'b1);
				4'd12: add(EDGE_RIGHT, EDGE_LEFT, c, x, y, iso, cs, 1'b1);
				4'd13: add(EDGE_RIGHT, EDGE_BOTTOM, c, x, y, iso, cs, 1'b1);
				default: add(EDGE_BOTTOM, EDGE_LEFT, c, x, y, iso, cs, 1'b1);
			endcase
		endfunction

		function automatic void field(string name, logic [PW-1:0] want, logic [PW-1:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		function automatic void check_segment(segment_t got);
			segment_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected segment, expected none, actual %h %h %h %h",
					$time, got.sx, got.sy, got.ex, got.ey);
				return;
			end
			want = pending.pop_front();
			checked++;
			field("start_x", want.sx, got.sx);
			field("start_y", want.sy, got.sy);
			field("end_x", want.ex, got.ex);
			field("end_y", want.ey, got.ey);
			field("case_index", PW'(want.cs), PW'(got.cs));
			field("last_segment", PW'(want.last), PW'(got.last));
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic          busy;
	logic [VB-1:0] corner_top_left = '0;
	logic [VB-1:0] corner_top_right = '0;
	logic [VB-1:0] corner_bottom_left = '0;
	logic [VB-1:0] corner_bottom_right = '0;
	logic [CB-1:0] cell_x = '0;
	logic [CB-1:0] cell_y = '0;
	logic [VB-1:0] threshold = '0;
	logic          strobe;
	logic [PW-1:0] start_x, start_y, end_x, end_y;
	logic [3:0]    case_index;
	logic          last_segment;

	segment_board board = new();

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	marching_squares_cell_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.corner_top_left(corner_top_left), .corner_top_right(corner_top_right),
		.corner_bottom_left(corner_bottom_left), .corner_bottom_right(corner_bottom_right),
		.cell_x(cell_x), .cell_y(cell_y), .threshold(threshold),
		.strobe(strobe), .start_x(start_x), .start_y(start_y), .end_x(end_x),
		.end_y(end_y), .case_index(case_index), .last_segment(last_segment)
	);

	// the receiver never stalls: every strobe is a finished transaction
	always @(posedge clk) begin
		if (arst_n && strobe)
			board.check_segment('{start_x, start_y, end_x, end_y, case_index, last_segment});
	end

	// present one cell, hold it until the block takes it, then predict
	task automatic send_cell(logic [VB-1:0] tl, logic [VB-1:0] tr, logic [VB-1:0] bl,
		logic [VB-1:0] br, logic [CB-1:0] x, logic [CB-1:0] y, logic [VB-1:0] iso);
		logic [VB-1:0] c[4];
		c = '{tl, tr, bl, br};
		start <= 1'b1;
		corner_top_left <= tl;
		corner_top_right <= tr;
		corner_bottom_left <= bl;
		corner_bottom_right <= br;
		cell_x <= x;
		cell_y <= y;
		threshold <= iso;
		do
			@(posedge clk);
		while (busy);
		board.note_cell(c, x, y, iso);
	endtask

	// sender gap: half back to back, otherwise mostly short waits and a few long ones
	task automatic sender_gap();
		int n;
		n = $urandom_range(0, 99);
		if (n < 50)
			n = 0;
		else if (n < 92)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(10, 60);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic [VB-1:0] near(logic [VB-1:0] iso);
		int v;
		v = int'(iso) + $urandom_range(0, 6) - 3;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return VB'(v);
	endfunction

	// corner above or below the isovalue, sometimes on it or close to it
	function automatic logic [VB-1:0] corner(logic hi, logic [VB-1:0] iso);
		int k;
		k = $urandom_range(0, 9);
		if (k == 0)
			return iso;
		if (k == 1)
			return near(iso);
		if (hi)
			return (iso == 16'hffff) ? iso : VB'($urandom_range(int'(iso) + 1, 65535));
		return VB'($urandom_range(0, int'(iso)));
	endfunction

	initial begin
		#10_000_000;
		$display("marching_squares_cell_top_tb: errors");
		$finish;
	end

	initial begin
		logic [VB-1:0] iso;
		logic [3:0]    want;
		int            wait_cycles;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every case, both saddle splits, far corner on iso,
		// flat edges, cells at the last coordinate, field extremes
		for (int cs = 0; cs < 16; cs++)
			send_cell(cs[3] ? 16'd900 : 16'd100, cs[2] ? 16'd900 : 16'd100,
				cs[0] ? 16'd900 : 16'd100, cs[1] ? 16'd900 : 16'd100,
				12'(cs * 37), 12'(cs * 91), 16'd500);
		send_cell(16'd600, 16'd0, 16'd0, 16'd600, 12'd5, 12'd6, 16'd500);
		send_cell(16'd0, 16'd600, 16'd600, 16'd0, 12'd5, 12'd6, 16'd500);
		send_cell(16'hffff, 16'd0, 16'hffff, 16'hffff, 12'hffe, 12'hffe, 16'hfffe);
		send_cell(16'hffff, 16'd0, 16'd0, 16'd0, 12'hfff, 12'hfff, 16'd0);
		send_cell(16'd0, 16'd7, 16'd7, 16'd7, 12'hfff, 12'd0, 16'd7);
		send_cell(16'd8, 16'd7, 16'd8, 16'd8, 12'd0, 12'hfff, 16'd7);
		send_cell(16'hffff, 16'hffff, 16'hffff, 16'hffff, 12'hfff, 12'hfff, 16'hffff);
		send_cell(16'd0, 16'd0, 16'd0, 16'd0, 12'd0, 12'd0, 16'd0);

		for (int i = 0; i < 1300; i++) begin
			sender_gap();
			if ($urandom_range(0, 9) == 0) begin
				send_cell(VB'($urandom), VB'($urandom), VB'($urandom), VB'($urandom),
					CB'($urandom), CB'($urandom), VB'($urandom));
			end else begin
				case ($urandom_range(0, 5))
					0: iso = '0;
					1: iso = '1;
					default: iso = VB'($urandom);
				endcase
				// favor saddles so both split directions get exercised
				want = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ?
					CASE_SADDLE_5 : CASE_SADDLE_A) : 4'($urandom);
				send_cell(corner(want[3], iso), corner(want[2], iso), corner(want[0], iso),
					corner(want[1], iso), CB'($urandom), CB'($urandom), iso);
			end
		end
		start <= 1'b0;

		wait_cycles = 0;
		while (board.pending.size() != 0 && wait_cycles < 10000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (FB + 10) @(posedge clk);

		$display("cells sent: %0d, saddle cells: %0d", board.cells, board.saddles);
		$display("segments checked: %0d, left over: %0d", board.checked,
			board.pending.size());
		if (board.errors == 0 && board.pending.size() == 0)
			$display("marching_squares_cell_top_tb: clean");
		else
			$display("marching_squares_cell_top_tb: errors");
		$finish;
	end

endmodule

### sim.f
hdl/msq_pkg.sv
hdl/msq_front.sv
hdl/msq_div.sv
hdl/msq_fifo.sv
hdl/msq_back.sv
hdl/marching_squares_cell_top.sv
test/marching_squares_cell_top_tb.sv
